// ----- rtl/sdc_pkg.sv -----
// shared types, constants and helpers for the seed diagonal clusterer
package sdc_pkg;

    // field widths
    localparam int DIAG_W    = 36;
    localparam int POS_W     = 35;
    localparam int LEN_W     = 16;
    localparam int SCORE_W   = 20;
    localparam int IDX_W     = 16;
    localparam int SIZE_W    = 17;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // stream widths
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 88;

    // threshold constants
    localparam logic [SCORE_W-1:0] THR_CAP  = SCORE_W'(50);
    localparam logic [SCORE_W-1:0] THR_STEP = SCORE_W'(50);
    localparam logic [REG_W-1:0]   RL_CAP   = REG_W'(250);
    // floor(v / 5) = (v * 205) >> 10 for v below 256
    localparam logic [9:0]         DIV5_MUL   = 10'd205;
    localparam int                 DIV5_SHIFT = 10;

    // saturation limits
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 1'd1;

    // one result transaction
    typedef struct packed {
        logic                 cand_valid;
        logic [POS_W-1:0]     pos_diff;
        logic [SCORE_W-1:0]   score;
        logic [IDX_W-1:0]     first_index;
        logic [SIZE_W-1:0]    count;
        logic                 list_done;
    } result_t;

    // results produced by one accepted seed
    typedef struct packed {
        logic [1:0] num;
        result_t    slot1;
        result_t    slot0;
    } push_t;

    // start threshold min(floor(read_length / 5), 50)
    function automatic logic [SCORE_W-1:0] start_threshold(input logic [REG_W-1:0] rl);
        logic [17:0] prod;
        logic [SCORE_W-1:0] res;
        prod = {10'd0, rl[7:0]} * {8'd0, DIV5_MUL};
        if (rl >= RL_CAP)
            res = THR_CAP;
        else
            res = SCORE_W'(prod[17:DIV5_SHIFT]);
        return res;
    endfunction

endpackage

// ----- rtl/sdc_cluster_core.sv -----
// cluster state and the per-seed join, close and threshold logic
module sdc_cluster_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [sdc_pkg::DIAG_W-1:0]      pos_diff,
    input  logic [sdc_pkg::LEN_W-1:0]       seed_length,
    input  logic                            end_of_list,
    input  logic                            cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdc_pkg::REG_W-1:0]       cfg_wdata,
    output sdc_pkg::push_t                  push
);
    import sdc_pkg::*;

    logic                 open_reg;
    logic [POS_W-1:0]     last_diag_reg;
    logic [POS_W-1:0]     first_diag_reg;
    logic [SCORE_W-1:0]   score_reg;
    logic [IDX_W-1:0]     start_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [SCORE_W-1:0]   thr_reg;
    logic [SCORE_W-1:0]   start_thr_reg;
    logic [REG_W-1:0]     max_gap_reg;

    logic                 seed_neg;
    logic [POS_W-1:0]     d_pos;
    logic signed [DIAG_W-1:0] diff;
    logic                 join_c;
    logic [SCORE_W:0]     sum;
    logic [SCORE_W-1:0]   sum_sat;
    logic                 close1;
    logic                 close2;
    logic [SCORE_W-1:0]   thr_a;
    logic [SCORE_W-1:0]   thr_next;
    logic                 open_a;
    logic [POS_W-1:0]     first_a;
    logic [POS_W-1:0]     last_a;
    logic [SCORE_W-1:0]   score_a;
    logic [IDX_W-1:0]     start_a;
    logic [SIZE_W-1:0]    size_a;
    result_t              res_old;
    result_t              res_new;
    result_t              res_empty;

    // join test against the last member
    always_comb
    begin
        seed_neg = pos_diff[DIAG_W-1];
        d_pos    = pos_diff[POS_W-1:0];
        diff     = $signed({1'b0, d_pos}) - $signed({1'b0, last_diag_reg});
        join_c   = open_reg && ((diff == '0) ||
                   (diff < $signed({{(DIAG_W-REG_W){1'b0}}, max_gap_reg})));
        sum      = {1'b0, score_reg} + {{(SCORE_W+1-LEN_W){1'b0}}, seed_length};
        sum_sat  = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
    end

    // seed step: join, or close and restart; a negative pos_diff leaves the cluster as is
    always_comb
    begin
        open_a  = open_reg;
        first_a = first_diag_reg;
        last_a  = last_diag_reg;
        score_a = score_reg;
        start_a = start_reg;
        size_a  = size_reg;
        close1  = 1'b0;
        thr_a   = thr_reg;
        if (!seed_neg) begin
            if (join_c) begin
                score_a = sum_sat;
                size_a  = (size_reg == SIZE_MAX) ? size_reg : size_reg + 1'b1;
                last_a  = d_pos;
            end else begin
                close1 = open_reg && (score_reg > thr_reg);
                if (close1 && ({1'b0, score_reg} > {1'b0, thr_reg} + {1'b0, THR_STEP}))
                    thr_a = score_reg - THR_STEP;
                open_a  = 1'b1;
                first_a = d_pos;
                last_a  = d_pos;
                score_a = SCORE_W'(seed_length);
                start_a = index_reg;
                size_a  = SIZE_W'(1);
            end
        end
    end

    // end of list close
    always_comb
    begin
        close2   = end_of_list && open_a && (score_a > thr_a);
        thr_next = thr_a;
        if (close2 && ({1'b0, score_a} > {1'b0, thr_a} + {1'b0, THR_STEP}))
            thr_next = score_a - THR_STEP;
    end

    // result slots
    always_comb
    begin
        res_old   = '{cand_valid: 1'b1, pos_diff: first_diag_reg, score: score_reg,
                      first_index: start_reg, count: size_reg, list_done: 1'b0};
        res_new   = '{cand_valid: 1'b1, pos_diff: first_a, score: score_a,
                      first_index: start_a, count: size_a, list_done: 1'b0};
        res_empty = '0;
        res_empty.list_done = 1'b1;

        push.slot1 = res_new;
        push.slot1.list_done = end_of_list;
        if (close1) begin
            push.slot0 = res_old;
            push.slot0.list_done = end_of_list && !close2;
        end else if (close2) begin
            push.slot0 = res_new;
            push.slot0.list_done = 1'b1;
        end else begin
            push.slot0 = res_empty;
        end

        if (!accept)
            push.num = 2'd0;
        else if (close1 && close2)
            push.num = 2'd2;
        else if (close1 || close2 || end_of_list)
            push.num = 2'd1;
        else
            push.num = 2'd0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            open_reg       <= 1'b0;
            last_diag_reg  <= '0;
            first_diag_reg <= '0;
            score_reg      <= '0;
            start_reg      <= '0;
            size_reg       <= '0;
            index_reg      <= '0;
            thr_reg        <= start_threshold(REG_W'(150));
            start_thr_reg  <= start_threshold(REG_W'(150));
            max_gap_reg    <= REG_W'(5);
        end else begin
            if (accept) begin
                last_diag_reg  <= last_a;
                first_diag_reg <= first_a;
                score_reg      <= score_a;
                start_reg      <= start_a;
                size_reg       <= size_a;
                if (end_of_list) begin
                    open_reg  <= 1'b0;
                    index_reg <= '0;
                end else begin
                    open_reg  <= open_a;
                    index_reg <= index_reg + 1'b1;
                end
            end
            // threshold: a read_length write reloads it at once
            if (cfg_we && (cfg_index == REG_READ_LENGTH))
                thr_reg <= start_threshold(cfg_wdata);
            else if (accept)
                thr_reg <= end_of_list ? start_thr_reg : thr_next;
            // configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_READ_LENGTH:
                    begin
                        start_thr_reg <= start_threshold(cfg_wdata);
                    end
                    REG_MAX_GAP:
                    begin
                        max_gap_reg <= cfg_wdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/sdc_result_fifo.sv -----
// small result queue taking up to two results per cycle
module sdc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  sdc_pkg::push_t    push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output sdc_pkg::result_t  out_data
);
    import sdc_pkg::*;

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign space     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem[wr_ptr_reg] <= push.slot0;
        if (push.num == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push.slot1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.num);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/seed_diagonal_clusterer.sv -----
// top level of the seed diagonal clusterer
// the results of an accepted seed are written into the result queue as it is accepted
// throughput: one seed per cycle while s_tready is high; a seed that closes two clusters
//   puts two results into a four-entry queue, which drains one per cycle under m_tready
// s_tready is low while the queue holds more than two results
// reset: asynchronous active low; clears cluster state, loads max_gap 5 and the start
//   threshold that matches read_length 150; no clearing pass
module seed_diagonal_clusterer (
    input  logic                            clk,
    input  logic                            rst_n,
    // input seeds
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sdc_pkg::S_DATA_W-1:0]    s_tdata,  // pos_diff[35:0], seed_length[51:36]
    input  logic                            s_tlast,  // end_of_list
    // result transactions
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sdc_pkg::M_DATA_W-1:0]    m_tdata,  // candidate_pos_diff[34:0],
                                                      // candidate_score[54:35],
                                                      // first_seed_index[70:55],
                                                      // seed_count[87:71]
    output logic [0:0]                      m_tuser,  // candidate_valid
    output logic                            m_tlast,  // list_done
    // configuration
    input  logic                            cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdc_pkg::REG_W-1:0]       cfg_wdata
);
    import sdc_pkg::*;

    push_t   push;
    result_t res;
    logic    space;
    logic    accept;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    sdc_cluster_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pos_diff    (s_tdata[DIAG_W-1:0]),
        .seed_length (s_tdata[DIAG_W +: LEN_W]),
        .end_of_list (s_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push)
    );

    sdc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // output packing
    assign m_tdata    = {res.count, res.first_index, res.score, res.pos_diff};
    assign m_tuser[0] = res.cand_valid;
    assign m_tlast    = res.list_done;

endmodule

// ----- rtl/sdc_checker.sv -----
// port-level checks for the seed diagonal clusterer and their binding
module sdc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sdc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tlast
);
    import sdc_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a result with no candidate only closes a list and carries zeros
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("empty result malformed");

    // a candidate holds at least one seed
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[87:71] != '0))
        else $error("candidate with no seeds");

    // a candidate beat a threshold of at least zero
    a_score: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[54:35] != '0))
        else $error("candidate with zero score");

endmodule

bind seed_diagonal_clusterer sdc_checker u_sdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
